/* hdl/dpc_pkg.sv */
// ----------------------------------------------------------------------------
// Dual PWM pulse capture package
// Payload and configuration types, register indexes and constants shared by
// the channel tracker, the angle converter and the top level.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int NUM_CH     = 2;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int WIDTH_W    = 12;
    localparam int DEG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_MIN = 2'd0,
        CFG_PERIOD_MAX = 2'd1,
        CFG_WIDTH_MIN  = 2'd2,
        CFG_WIDTH_MAX  = 2'd3
    } t_cfg_idx;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST = 16'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST = 16'd26000;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN_RST  = 12'd800;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX_RST  = 12'd2200;

    // Angle mapping: (clamp(w, LO, HI) - LO) * SPAN / (HI - LO) - OFFSET
    localparam logic [WIDTH_W-1:0] ANG_LO_US      = 12'd1000;
    localparam logic [WIDTH_W-1:0] ANG_HI_US      = 12'd2000;
    localparam int                 ANG_SPAN_DEG   = 180;
    localparam logic [DEG_W-1:0]   ANG_OFFSET_DEG = 8'd90;
    localparam int                 ANG_RANGE      = 1000;
    localparam int                 ANG_D_W        = 10;
    localparam int                 ANG_SHIFT      = 20;
    // Rounded-up reciprocal: error stays below 1/50 of a degree over the range
    localparam int                 ANG_RECIP      =
        (ANG_SPAN_DEG * (1 << ANG_SHIFT) + ANG_RANGE - 1) / ANG_RANGE;
    localparam int                 ANG_RECIP_W    = 18;
    localparam int                 ANG_PROD_W     = ANG_D_W + ANG_RECIP_W;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_min;
        logic [PERIOD_W-1:0] period_max;
        logic [WIDTH_W-1:0]  width_min;
        logic [WIDTH_W-1:0]  width_max;
    } t_cfg;

    typedef struct packed {
        logic [NUM_CH-1:0] pin_levels;
        logic [TIME_W-1:0] time_us;
    } t_in;

    typedef struct packed {
        logic signed [DEG_W-1:0] pitch_deg;
        logic signed [DEG_W-1:0] roll_deg;
        logic [WIDTH_W-1:0]      pitch_width;
        logic [WIDTH_W-1:0]      roll_width;
    } t_out;

endpackage

/* hdl/dpc_chan.sv */
// ----------------------------------------------------------------------------
// Channel edge tracker
// Holds edge timestamps, the armed flag and the last good width of one PWM
// channel; commits the update for one sample when enabled.
// ----------------------------------------------------------------------------
module dpc_chan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_level,
    input  logic                         i_last_level,
    input  logic [dpc_pkg::TIME_W-1:0]   i_time,
    input  dpc_pkg::t_cfg                i_cfg,
    output logic [dpc_pkg::WIDTH_W-1:0]  o_width
);

    logic [dpc_pkg::TIME_W-1:0]  r_rise;
    logic [dpc_pkg::TIME_W-1:0]  n_rise;
    logic [dpc_pkg::TIME_W-1:0]  r_fall;
    logic [dpc_pkg::TIME_W-1:0]  n_fall;
    logic                        r_armed;
    logic                        n_armed;
    logic [dpc_pkg::WIDTH_W-1:0] r_good;
    logic [dpc_pkg::WIDTH_W-1:0] n_good;
    logic [dpc_pkg::TIME_W-1:0]  low_time;
    logic [dpc_pkg::TIME_W-1:0]  high_time;
    logic                        period_ok;
    logic                        width_ok;

    // Modulo 2^32 differences
    assign low_time  = i_time - r_fall;
    assign high_time = i_time - r_rise;

    assign period_ok = (low_time >= dpc_pkg::TIME_W'(i_cfg.period_min)) &&
                       (low_time <= dpc_pkg::TIME_W'(i_cfg.period_max));
    assign width_ok  = (high_time >= dpc_pkg::TIME_W'(i_cfg.width_min)) &&
                       (high_time <= dpc_pkg::TIME_W'(i_cfg.width_max));

    always_comb begin
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_armed = r_armed;
        n_good  = r_good;
        if (i_level != i_last_level) begin
            if (i_level) begin
                n_rise  = i_time;
                n_armed = period_ok;
            end else begin
                n_fall = i_time;
                // out-of-window falling edge leaves armed alone
                if (width_ok && r_armed) begin
                    n_good  = high_time[dpc_pkg::WIDTH_W-1:0];
                    n_armed = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_armed <= 1'b0;
            r_good  <= '0;
        end else if (i_en) begin
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_armed <= n_armed;
            r_good  <= n_good;
        end
    end

    assign o_width = r_good;

endmodule

/* hdl/dpc_angle.sv */
// ----------------------------------------------------------------------------
// Width to angle converter
// Clamps a pulse width to the stick range and scales it to degrees with a
// reciprocal multiply; a zero width gives zero degrees.
// ----------------------------------------------------------------------------
module dpc_angle (
    input  logic [dpc_pkg::WIDTH_W-1:0]      i_width,
    output logic signed [dpc_pkg::DEG_W-1:0] o_deg
);

    logic [dpc_pkg::WIDTH_W-1:0]    clamped;
    logic [dpc_pkg::WIDTH_W-1:0]    offset;
    logic [dpc_pkg::ANG_PROD_W-1:0] prod;
    logic [dpc_pkg::DEG_W-1:0]      quot;

    always_comb begin
        priority if (i_width < dpc_pkg::ANG_LO_US) begin
            clamped = dpc_pkg::ANG_LO_US;
        end else if (i_width > dpc_pkg::ANG_HI_US) begin
            clamped = dpc_pkg::ANG_HI_US;
        end else begin
            clamped = i_width;
        end
    end

    assign offset = clamped - dpc_pkg::ANG_LO_US;
    assign prod   = dpc_pkg::ANG_PROD_W'(offset[dpc_pkg::ANG_D_W-1:0]) *
                    dpc_pkg::ANG_PROD_W'(dpc_pkg::ANG_RECIP);
    // truncate: take the integer part of the scaled product
    assign quot   = prod[dpc_pkg::ANG_PROD_W-1 -: dpc_pkg::DEG_W];

    assign o_deg  = (i_width == '0) ? '0 : signed'(quot - dpc_pkg::ANG_OFFSET_DEG);

endmodule

/* hdl/dual_pwm_pulse_capture.sv */
// Registered path from input transaction to result: input, state, output register.
// Throughput: one transaction per cycle when not stalled by i_ready; one result per
// input transaction. The channel state commit, at most once per cycle, sets the rate.
// Reset (synchronous, active low) clears all channel state and pipeline valids,
// and loads the window registers with their default values.
// ----------------------------------------------------------------------------
// Dual PWM pulse capture
// Tracks pitch and roll RC PWM pins, validates period and pulse width and
// reports the last good widths together with their angles.
// ----------------------------------------------------------------------------
module dual_pwm_pulse_capture (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  dpc_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output dpc_pkg::t_out                     o_data,
    input  logic                              i_cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    dpc_pkg::t_cfg                       r_cfg;
    dpc_pkg::t_in                        r_in;
    logic                                r_in_vld;
    logic                                r_mid_vld;
    logic [dpc_pkg::NUM_CH-1:0]          r_last;
    dpc_pkg::t_out                       r_out;
    logic                                r_out_vld;
    logic                                out_adv;
    logic                                mid_adv;
    logic                                in_adv;
    logic                                commit;
    logic [dpc_pkg::WIDTH_W-1:0]         width [dpc_pkg::NUM_CH];
    logic signed [dpc_pkg::DEG_W-1:0]    deg   [dpc_pkg::NUM_CH];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_min <= dpc_pkg::PERIOD_MIN_RST;
            r_cfg.period_max <= dpc_pkg::PERIOD_MAX_RST;
            r_cfg.width_min  <= dpc_pkg::WIDTH_MIN_RST;
            r_cfg.width_max  <= dpc_pkg::WIDTH_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (dpc_pkg::t_cfg_idx'(i_cfg_idx))
                dpc_pkg::CFG_PERIOD_MIN: r_cfg.period_min <= i_cfg_data;
                dpc_pkg::CFG_PERIOD_MAX: r_cfg.period_max <= i_cfg_data;
                dpc_pkg::CFG_WIDTH_MIN:  r_cfg.width_min  <=
                                             i_cfg_data[dpc_pkg::WIDTH_W-1:0];
                dpc_pkg::CFG_WIDTH_MAX:  r_cfg.width_max  <=
                                             i_cfg_data[dpc_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: each stage moves when the one after it is free
    assign out_adv = !r_out_vld || i_ready;
    assign mid_adv = !r_mid_vld || out_adv;
    assign in_adv  = !r_in_vld  || mid_adv;
    assign commit  = r_in_vld && mid_adv;
    assign o_ready = in_adv;

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_last    <= '0;
        end else begin
            if (in_adv) begin
                r_in_vld <= i_valid;
            end
            if (mid_adv) begin
                r_mid_vld <= r_in_vld;
            end
            if (out_adv) begin
                r_out_vld <= r_mid_vld;
            end
            if (commit) begin
                r_last <= r_in.pin_levels;
            end
        end
    end

    // Channel state doubles as the middle stage: it holds until the next commit
    for (genvar ch = 0; ch < dpc_pkg::NUM_CH; ch++) begin : g_ch
        dpc_chan u_chan (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (commit),
            .i_level      (r_in.pin_levels[ch]),
            .i_last_level (r_last[ch]),
            .i_time       (r_in.time_us),
            .i_cfg        (r_cfg),
            .o_width      (width[ch])
        );

        dpc_angle u_angle (
            .i_width (width[ch]),
            .o_deg   (deg[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out.pitch_deg   <= deg[0];
            r_out.roll_deg    <= deg[1];
            r_out.pitch_width <= width[0];
            r_out.roll_width  <= width[1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef SYNTH
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_commit_fills_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_mid_vld)
        else $error("state commit without a pending result");

    a_stall_holds_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_vld && !mid_adv) |=> (r_mid_vld && $stable(width[0]) && $stable(width[1])))
        else $error("stalled widths changed");

    a_zero_width_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.pitch_width == '0)) |-> (o_data.pitch_deg == '0))
        else $error("non-zero pitch angle without a stored width");
`endif

endmodule
